[rtl/core/lzw_encoder_core_defines.svh]
// Assertion macros shared by the checker of the LZW encoder core.
// No dependencies; the macros expect clk and arst_n in scope.
`ifndef LZW_ENCODER_CORE_DEFINES_SVH
`define LZW_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LZWE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lzwe_checker: property failed");

// Next-cycle implication, disabled while reset is asserted.
`define LZWE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lzwe_checker: property failed");

`endif

[rtl/core/lzwe_pkg.sv]
// Package of the LZW encoder core: widths, codes, request types and FSM states.
// No dependencies.
`default_nettype none

package lzwe_pkg;

	localparam int SYM_W        = 5;
	localparam int CODE_W       = 8;
	localparam int KEY_W        = CODE_W + SYM_W;
	localparam int BASE_CODES   = 27;
	localparam int MAX_CODES    = 256;
	localparam int DICT_SIZE_DEF = 256;

	// Classified request handed from front to back
	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             has_sym;
		logic             eos;
	} op_t;

	// One result request
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MISS,
		ST_FLUSH
	} state_t;

endpackage

`default_nettype wire

[rtl/core/lzwe_if.sv]
// Valid/ready channel interfaces of the LZW encoder core.
// Depends on lzwe_pkg for field widths.
`default_nettype none

interface lzwe_in_if;
	logic                        valid;
	logic                        ready;
	logic [lzwe_pkg::SYM_W-1:0]  symbol;
	logic                        end_of_stream;

	modport source (output valid, output symbol, output end_of_stream, input ready);
	modport sink   (input valid, input symbol, input end_of_stream, output ready);
endinterface

interface lzwe_out_if;
	logic                        valid;
	logic                        ready;
	logic [lzwe_pkg::CODE_W-1:0] out_code;
	logic                        last_code;

	modport source (output valid, output out_code, output last_code, input ready);
	modport sink   (input valid, input out_code, input last_code, output ready);
endinterface

`default_nettype wire

[rtl/core/lzwe_fifo.sv]
// Two-entry request queue, any payload width.
// Depends on lzwe_pkg for the default width.
`default_nettype none

module lzwe_fifo #(
	parameter int WIDTH = $bits(lzwe_pkg::op_t)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

[rtl/core/lzwe_front.sv]
// Front end: accepts symbol requests, classifies them and queues them.
// Depends on lzwe_pkg, lzwe_if and lzwe_fifo.
`default_nettype none

module lzwe_front (
	input  wire logic      clk,
	input  wire logic      arst_n,
	lzwe_in_if.sink        symbols,
	output lzwe_pkg::op_t  op,
	output logic           op_empty,
	input  wire logic      op_pop
);

	lzwe_pkg::op_t op_in;
	logic          keep;
	logic          full;

	always_comb begin
		op_in.sym     = symbols.symbol;
		op_in.has_sym = (symbols.symbol < lzwe_pkg::SYM_W'(lzwe_pkg::BASE_CODES));
		op_in.eos     = symbols.end_of_stream;
	end

	// out-of-range symbol without end of stream has no effect: drop it here
	assign keep          = op_in.has_sym || op_in.eos;
	assign symbols.ready = !full;

	lzwe_fifo #(
		.WIDTH ($bits(lzwe_pkg::op_t))
	) u_opq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (symbols.valid && !full && keep),
		.push_data (op_in),
		.full      (full),
		.pop       (op_pop),
		.pop_data  (op),
		.empty     (op_empty)
	);

endmodule

`default_nettype wire

[rtl/core/lzwe_back.sv]
// Back end: dictionary search engine, dictionary memory and result queue.
// Depends on lzwe_pkg, lzwe_if and lzwe_fifo.
`default_nettype none

module lzwe_back #(
	parameter int DICT_SIZE = lzwe_pkg::DICT_SIZE_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lzwe_pkg::op_t  op,
	input  wire logic           op_empty,
	output logic                op_pop,
	lzwe_out_if.source          codes
);

	localparam int CODE_LIMIT = (DICT_SIZE < lzwe_pkg::MAX_CODES) ? DICT_SIZE
	                                                             : lzwe_pkg::MAX_CODES;
	localparam int NF_W  = $clog2(CODE_LIMIT + 1);
	localparam int IDX_W = $clog2(CODE_LIMIT);
	localparam logic [NF_W-1:0] BASE_NF  = NF_W'(lzwe_pkg::BASE_CODES);
	localparam logic [NF_W-1:0] LIMIT_NF = NF_W'(CODE_LIMIT);

	lzwe_pkg::state_t state_q, state_nx;

	logic [lzwe_pkg::SYM_W-1:0]  sym_q;
	logic                        eos_q;
	logic [lzwe_pkg::CODE_W-1:0] prefix_q;
	logic                        pvalid_q;
	logic [NF_W-1:0]             next_free_q;
	logic [NF_W-1:0]             idx_q;
	logic [NF_W-1:0]             cmp_idx_s1;
	logic                        cmp_vld_s1;
	logic [lzwe_pkg::KEY_W-1:0]  rd_data_s1;
	logic [lzwe_pkg::KEY_W-1:0]  dict_mem [CODE_LIMIT];

	logic [lzwe_pkg::KEY_W-1:0]  key;
	logic                        hit;
	logic                        scan_done;
	logic                        issue;
	logic                        mem_we;
	logic                        out_push;
	lzwe_pkg::res_t              out_data;
	logic                        out_full;
	logic                        out_empty;
	lzwe_pkg::res_t              out_head;
	logic                        flush_done;

	assign key       = {prefix_q, sym_q};
	assign hit       = cmp_vld_s1 && (rd_data_s1 == key);
	assign scan_done = !cmp_vld_s1 && (idx_q == next_free_q);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			lzwe_pkg::ST_IDLE: begin
				if (!op_empty) begin
					if (op.has_sym && pvalid_q) state_nx = lzwe_pkg::ST_SEARCH;
					else if (op.eos)            state_nx = lzwe_pkg::ST_FLUSH;
				end
			end
			lzwe_pkg::ST_SEARCH: begin
				if (hit)            state_nx = eos_q ? lzwe_pkg::ST_FLUSH : lzwe_pkg::ST_IDLE;
				else if (scan_done) state_nx = lzwe_pkg::ST_MISS;
			end
			lzwe_pkg::ST_MISS: begin
				if (!out_full) state_nx = eos_q ? lzwe_pkg::ST_FLUSH : lzwe_pkg::ST_IDLE;
			end
			lzwe_pkg::ST_FLUSH: begin
				if (!pvalid_q || !out_full) state_nx = lzwe_pkg::ST_IDLE;
			end
			default: state_nx = lzwe_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		op_pop        = 1'b0;
		issue         = 1'b0;
		mem_we        = 1'b0;
		out_push      = 1'b0;
		out_data.code = prefix_q;
		out_data.last = 1'b0;
		flush_done    = 1'b0;
		unique case (state_q)
			lzwe_pkg::ST_IDLE: begin
				op_pop = !op_empty;
			end
			lzwe_pkg::ST_SEARCH: begin
				issue = !hit && (idx_q < next_free_q);
			end
			lzwe_pkg::ST_MISS: begin
				out_push = !out_full;
				mem_we   = !out_full && (next_free_q < LIMIT_NF);
			end
			lzwe_pkg::ST_FLUSH: begin
				out_push      = pvalid_q && !out_full;
				out_data.last = 1'b1;
				flush_done    = !pvalid_q || !out_full;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lzwe_pkg::ST_IDLE;
			pvalid_q    <= 1'b0;
			prefix_q    <= '0;
			next_free_q <= BASE_NF;
			idx_q       <= BASE_NF;
			cmp_vld_s1  <= 1'b0;
		end else begin
			state_q    <= state_nx;
			cmp_vld_s1 <= issue;
			if (op_pop) begin
				idx_q <= BASE_NF;
				if (op.has_sym && !pvalid_q) begin
					prefix_q <= lzwe_pkg::CODE_W'(op.sym);
					pvalid_q <= 1'b1;
				end
			end
			if (issue) idx_q <= idx_q + 1'b1;
			if (state_q == lzwe_pkg::ST_SEARCH && hit)
				prefix_q <= lzwe_pkg::CODE_W'(cmp_idx_s1);
			if (state_q == lzwe_pkg::ST_MISS && !out_full)
				prefix_q <= lzwe_pkg::CODE_W'(sym_q);
			if (mem_we) next_free_q <= next_free_q + 1'b1;
			if (flush_done) begin
				pvalid_q    <= 1'b0;
				prefix_q    <= '0;
				next_free_q <= BASE_NF;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			sym_q <= op.sym;
			eos_q <= op.eos;
		end
		cmp_idx_s1 <= idx_q;
	end

	// dictionary: entries from code 27 up to next_free are always written since the last clear
	always_ff @(posedge clk) begin
		if (mem_we) dict_mem[next_free_q[IDX_W-1:0]] <= key;
		rd_data_s1 <= dict_mem[idx_q[IDX_W-1:0]];
	end

	lzwe_fifo #(
		.WIDTH ($bits(lzwe_pkg::res_t))
	) u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (out_push),
		.push_data (out_data),
		.full      (out_full),
		.pop       (codes.ready),
		.pop_data  (out_head),
		.empty     (out_empty)
	);

	assign codes.valid     = !out_empty;
	assign codes.out_code  = out_head.code;
	assign codes.last_code = out_head.last;

endmodule

`default_nettype wire

[rtl/core/lzw_encoder_core.sv]
// Back end, per accepted request: with no prefix pending it just starts one; with a prefix,
//   it scans from code 27 until a hit, or misses once every learnt code has been read;
//   end of stream adds a flush step, and a full result queue stalls a miss or a flush.
// Throughput: one symbol at a time, bounded by the one-read-per-cycle dictionary scan
//   (up to min(DICT_SIZE,256) - 27 reads, i.e. <= 229 at the default size).
// Reset (arst_n low, asynchronous): queues empty, no prefix, 27 base codes, no clearing pass.
`default_nettype none

// Top level of the LZW encoder.
// Front: takes symbol requests, drops out-of-range symbols that carry no end of
// stream, and queues up to two requests so the input side keeps moving while the
// back end scans.
// Back: per request, either starts a prefix, or scans the dictionary linearly from
// code 27 up to next_free (one memory read per cycle, compared on the registered read data).
// A hit extends the prefix; a miss emits the prefix, adds (prefix, symbol) while
// room remains and restarts from the symbol. End of stream flushes the prefix with
// last_code set and restores the dictionary to its 27 base codes.
// Results go through a two-entry queue, so a stalled sink only halts the back end
// when it has a result to push.
// The fill count hides stale dictionary entries, so no clearing pass is needed.
module lzw_encoder_core #(
	parameter int DICT_SIZE = lzwe_pkg::DICT_SIZE_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lzwe_in_if.sink   symbols,
	lzwe_out_if.source codes
);

	lzwe_pkg::op_t op;
	logic          op_empty;
	logic          op_pop;

	lzwe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.symbols  (symbols),
		.op       (op),
		.op_empty (op_empty),
		.op_pop   (op_pop)
	);

	lzwe_back #(
		.DICT_SIZE (DICT_SIZE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.op_empty (op_empty),
		.op_pop   (op_pop),
		.codes    (codes)
	);

endmodule

`default_nettype wire

[rtl/core/lzwe_checker.sv]
// Port-level checker of the LZW encoder core, bound to the top level.
// Depends on lzw_encoder_core_defines.svh and lzwe_pkg.
`default_nettype none
`include "lzw_encoder_core_defines.svh"

module lzwe_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [lzwe_pkg::CODE_W-1:0] out_code,
	input wire logic                        out_last
);

	// input side only fills up after taking a request
	`LZWE_ASSERT_NOW(a_ready_fall, $fell(in_ready), $past(in_valid))
	// result queue comes out of reset empty
	`LZWE_ASSERT_NOW(a_reset_empty, $rose(arst_n), !out_valid)
	// stalled result holds
	`LZWE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_code) && $stable(out_last))
	// result withdrawn only once taken
	`LZWE_ASSERT_NOW(a_out_keep, $fell(out_valid), $past(out_ready))

endmodule

bind lzw_encoder_core lzwe_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (symbols.valid),
	.in_ready  (symbols.ready),
	.out_valid (codes.valid),
	.out_ready (codes.ready),
	.out_code  (codes.out_code),
	.out_last  (codes.last_code)
);

`default_nettype wire

[sim/lzw_encoder_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for lzw_encoder_core: directed and random symbol streams,
// predicted codes checked in order. Depends on lzwe_pkg, lzwe_if and the core RTL.

module lzw_encoder_core_tb;
	import lzwe_pkg::*;

	// Code space actually usable: codes are CODE_W bits wide
	localparam int CODE_LIMIT  = (DICT_SIZE_DEF < MAX_CODES) ? DICT_SIZE_DEF : MAX_CODES;
	localparam int HOLD_AT     = 30;   // requests taken before the long sink stall
	localparam int HOLD_CYCLES = 1000;
	localparam int DRAIN       = 600;  // > one full-table scan plus slack
	localparam int MAX_REPORTS = 40;
	localparam int MSG_SYMS    = 1500; // message symbols in the random part

	// One pending symbol request
	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             eos;
	} sym_req_t;

	logic clk = 1'b0;
	logic arst_n;

	always #2 clk = ~clk;

	lzwe_in_if  sym_req ();
	lzwe_out_if code_res ();

	lzw_encoder_core #(
		.DICT_SIZE(DICT_SIZE_DEF)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.symbols(sym_req),
		.codes  (code_res)
	);

	sym_req_t stim_q[$];        // requests still to be offered
	res_t     expected_codes[$]; // codes predicted, oldest first
	int       stim_total  = 0;
	int       items_taken = 0;
	int       errors      = 0;

	// Encoder shadow: dictionary keys {prefix, symbol}, fill pointer, open prefix
	logic [KEY_W-1:0]  dict_key [0:MAX_CODES-1];
	int                dict_fill;
	logic [CODE_W-1:0] cur_prefix;
	bit                have_prefix;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Back to the 27 single-symbol codes; stale entries above are hidden by the fill
	function automatic void dict_reset();
		for (int i = 0; i < MAX_CODES; i++) begin
			dict_key[i] = (i < BASE_CODES) ? KEY_W'(i) : '0;
		end
		dict_fill = BASE_CODES;
	endfunction

	// Linear search over the learnt entries; -1 when the pair is absent
	function automatic int dict_lookup(logic [CODE_W-1:0] pre, logic [SYM_W-1:0] s);
		for (int i = BASE_CODES; i < dict_fill; i++) begin
			if (dict_key[i] == {pre, s})
				return i;
		end
		return -1;
	endfunction

	// Advance the shadow encoder by one symbol request and queue the codes it emits
	function automatic void encode_symbol(logic [SYM_W-1:0] s, logic eos);
		int   hit;
		res_t r;
		if (s < BASE_CODES) begin
			if (!have_prefix) begin
				cur_prefix  = CODE_W'(s);
				have_prefix = 1'b1;
			end else begin
				hit = dict_lookup(cur_prefix, s);
				if (hit >= 0) begin
					cur_prefix = hit[CODE_W-1:0];
				end else begin
					r.code = cur_prefix;
					r.last = 1'b0;
					expected_codes.push_back(r);
					// table full: keep coding with what we have
					if (dict_fill < CODE_LIMIT) begin
						dict_key[dict_fill] = {cur_prefix, s};
						dict_fill++;
					end
					cur_prefix = CODE_W'(s);
				end
			end
		end
		// end of stream flushes even on an out-of-range symbol
		if (eos) begin
			if (have_prefix) begin
				r.code = cur_prefix;
				r.last = 1'b1;
				expected_codes.push_back(r);
			end
			cur_prefix  = '0;
			have_prefix = 1'b0;
			dict_reset();
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic void push_req(int s, bit eos);
		sym_req_t t;
		t.sym = SYM_W'(s);
		t.eos = eos;
		stim_q.push_back(t);
	endfunction

	// 0: sender light / sink heavy idling, 1: the reverse, 2: no idling
	function automatic int load_phase();
		return (stim_total == 0) ? 2 : (items_taken * 3) / stim_total;
	endfunction

	// ------------------------------------------------------------------
	// Driver: offers the head of stim_q, holds it until the core takes it
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		int ph;
		int idle_pct;
		if (!arst_n) begin
			sym_req.valid         <= 1'b0;
			sym_req.symbol        <= '0;
			sym_req.end_of_stream <= 1'b0;
		end else if (!sym_req.valid || sym_req.ready) begin
			ph       = load_phase();
			idle_pct = (ph == 0) ? 12 : (ph == 1) ? 46 : 0;
			if (stim_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				sym_req.valid         <= 1'b1;
				sym_req.symbol        <= stim_q[0].sym;
				sym_req.end_of_stream <= stim_q[0].eos;
				stim_q.delete(0);
			end else begin
				sym_req.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sink ready: random stalls, plus one long hold-off so both internal
	// queues fill and the core has to back-pressure the symbol side
	// ------------------------------------------------------------------
	int hold_left;
	bit hold_done;

	always @(posedge clk or negedge arst_n) begin
		int ph;
		int idle_pct;
		if (!arst_n) begin
			code_res.ready <= 1'b0;
			hold_left      <= 0;
			hold_done      <= 1'b0;
		end else if (!hold_done && items_taken >= HOLD_AT) begin
			hold_done      <= 1'b1;
			hold_left      <= HOLD_CYCLES;
			code_res.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left      <= hold_left - 1;
			code_res.ready <= 1'b0;
		end else begin
			ph             = load_phase();
			idle_pct       = (ph == 0) ? 46 : (ph == 1) ? 12 : 0;
			code_res.ready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check any result first, then predict from an accepted
	// symbol request. A request cannot produce a code on its own edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (code_res.valid && code_res.ready) begin
				if (expected_codes.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected code: expected none, got %0d last %0b",
							$time, code_res.out_code, code_res.last_code);
				end else begin
					want = expected_codes.pop_front();
					if (code_res.out_code !== want.code) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: out_code mismatch: expected %0d, got %0d",
								$time, want.code, code_res.out_code);
					end
					if (code_res.last_code !== want.last) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: last_code mismatch: expected %0b, got %0b",
								$time, want.last, code_res.last_code);
					end
				end
			end
			if (sym_req.valid && sym_req.ready) begin
				encode_symbol(sym_req.symbol, sym_req.end_of_stream);
				items_taken <= items_taken + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus build, reset, end of run
	// ------------------------------------------------------------------
	initial begin
		int  counted;
		int  len;
		int  lo;
		int  span;
		bit  first_long;
		bit  is_last;

		// reset asserted and predictor cleared before the first edge
		arst_n      = 1'b0;
		cur_prefix  = '0;
		have_prefix = 1'b0;
		dict_reset();

		// Directed: single symbol message
		push_req(1, 1'b1);
		// end of stream with nothing pending, symbol out of range: no code
		push_req(31, 1'b1);
		// alphabet extremes, repeated symbol hitting a learnt pair at the end
		push_req(0, 1'b0);
		push_req(26, 1'b0);
		push_req(26, 1'b0);
		push_req(26, 1'b1);
		// ignored symbol mid-message, hits on learnt pairs, flush via out-of-range
		push_req(1, 1'b0);
		push_req(2, 1'b0);
		push_req(27, 1'b0);
		push_req(1, 1'b0);
		push_req(2, 1'b0);
		push_req(1, 1'b0);
		push_req(2, 1'b0);
		push_req(30, 1'b1);
		// run of one symbol builds ever longer prefixes
		for (int i = 0; i < 6; i++)
			push_req(3, i == 5);
		push_req(16, 1'b1);

		// Random messages. Mostly well-formed, some long enough to fill the
		// table, some over a narrow alphabet for deep prefix chains; noise of
		// ignored symbols, flushes on out-of-range symbols and empty flushes.
		counted    = 0;
		first_long = 1'b1;
		while (counted < MSG_SYMS) begin
			if (first_long || $urandom_range(0, 99) < 6)
				len = $urandom_range(300, 420);
			else
				len = $urandom_range(1, 40);
			if (len > MSG_SYMS - counted)
				len = MSG_SYMS - counted;
			span = (!first_long && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 26;
			lo   = $urandom_range(0, 26 - span);
			first_long = 1'b0;
			for (int i = 0; i < len; i++) begin
				is_last = (i == len - 1);
				if ($urandom_range(0, 49) == 0)
					push_req($urandom_range(27, 31), 1'b0);
				if (is_last && $urandom_range(0, 9) == 0)
					push_req($urandom_range(27, 31), 1'b1);
				else
					push_req(lo + $urandom_range(0, span), is_last);
				counted++;
			end
			if ($urandom_range(0, 19) == 0)
				push_req($urandom_range(0, 31), 1'b1);
		end
		stim_total = stim_q.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (!(items_taken == stim_total && expected_codes.size() == 0))
			@(posedge clk);
		// trailing requests that emit nothing may still be scanning
		repeat (DRAIN) @(posedge clk);
		if (expected_codes.size() != 0) begin
			errors++;
			$display("%0t: %0d codes expected but never seen", $time, expected_codes.size());
		end

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog, several times the slowest legal run
	initial begin
		#(10_000_000);
		$display("Verification failed");
		$finish;
	end

endmodule
